>>> rtl/core/fca_pkg.sv
package fca_pkg;

   // Field widths
   localparam int OFFSET_W   = 12;
   localparam int CHUNK_W    = 13;
   localparam int STATUS_W   = 2;
   localparam int OPCODE_W   = 1;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // Default geometry
   localparam int PAGE_BYTES_DEF  = 4096;
   localparam int STACK_DEPTH_DEF = 4096;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOCFG    = 2'd1,
      STATUS_OOM      = 2'd2,
      STATUS_BAD_FREE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_POP,
      ST_FINISH
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       capture;
      logic       set_res;
      status_type res_code;
      logic       grant_bump;
      logic       pop_read;
      logic       pop_take;
      logic       div_start;
      logic       push;
      logic       load_rsp;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic cfg_zero;
      logic op_free;
      logic stack_empty;
      logic stack_full;
      logic oom;
      logic off_ge_bump;
      logic div_busy;
      logic rem_zero;
      logic rsp_free;
   } dp_sts_type;

endpackage

>>> rtl/core/fca_chan_if.sv
// Request channel: one allocate or free per beat
interface fca_req_if;
   import fca_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [OFFSET_W-1:0] chunk_offset;

   modport source (output valid, output opcode, output chunk_offset, input ready);
   modport sink   (input valid, input opcode, input chunk_offset, output ready);
endinterface

// Response channel: one result per request beat
interface fca_rsp_if;
   import fca_pkg::*;

   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] granted_offset;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output granted_offset, output status, input ready);
   modport sink   (input valid, input granted_offset, input status, output ready);
endinterface

>>> rtl/core/fixed_chunk_allocator.sv
// Channel   Dir  Beat payload                       Handshake
// req_bus   in   opcode, chunk_offset               valid/ready
// rsp_bus   out  granted_offset, status             valid/ready
// csr_*     in   chunk_size register (APB style)    psel/penable, pready tied high
//
// Allocate: capture, evaluate, finish; popping the free stack adds a pop state for the registered memory read.
// Free: capture, evaluate, the remainder unit at one offset bit per cycle (12 bits), then finish;
// a free rejected before the remainder check goes straight to finish, as does any not-configured beat.
// One request is in flight at a time; the next is taken while the result waits in the
// output register, and a result stall holds the controller until that register drains.
// Reset clears the chunk size, bump pointer, stack count and output valid; the stack
// memory is not cleared.
module fixed_chunk_allocator #(
   parameter int PAGE_BYTES  = fca_pkg::PAGE_BYTES_DEF,
   parameter int STACK_DEPTH = fca_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   fca_req_if.sink                        req_bus,
   fca_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fca_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fca_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fca_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import fca_pkg::*;

   logic [CHUNK_W-1:0] chunk_size_ff, chunk_size_in;
   logic               csr_write;
   dp_cmd_type         cmd;
   dp_sts_type         sts;

   // Single register with no address decode: reads and writes reach it at every address
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == '0) ? CSR_DATA_W'(chunk_size_ff) : CSR_DATA_W'(chunk_size_ff);

   always_comb begin
      chunk_size_in = chunk_size_ff;
      if (csr_write) begin
         chunk_size_in = csr_pwdata[CHUNK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= '0;
      end else begin
         chunk_size_ff <= chunk_size_in;
      end
   end

   fca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fca_dp #(
      .PAGE_BYTES  (PAGE_BYTES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .chunk_size         (chunk_size_ff),
      .req_opcode         (req_bus.opcode),
      .req_chunk_offset   (req_bus.chunk_offset),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_granted_offset (rsp_bus.granted_offset),
      .rsp_status         (rsp_bus.status)
   );

endmodule

>>> rtl/core/fca_rem.sv
// Restoring remainder unit, one dividend bit per cycle
module fca_rem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fca_pkg::OFFSET_W-1:0] dividend,
   input  logic [fca_pkg::CHUNK_W-1:0]  divisor,
   output logic                         busy,
   output logic                         remainder_zero
);
   import fca_pkg::*;

   localparam int STEP_W = $clog2(OFFSET_W + 1);

   logic [CHUNK_W-1:0]  rem_ff, rem_in;
   logic [OFFSET_W-1:0] shift_ff, shift_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic [CHUNK_W:0]    trial;

   // Bring down the next dividend bit and subtract when it fits
   assign trial = {rem_ff, shift_ff[OFFSET_W-1]};

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = '0;
         shift_in = dividend;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = CHUNK_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[CHUNK_W-1:0];
         end
         shift_in = {shift_ff[OFFSET_W-2:0], 1'b0};
         step_in  = step_ff + 1'b1;
         if (step_ff == STEP_W'(OFFSET_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign busy           = busy_ff;
   assign remainder_zero = (rem_ff == '0);

endmodule

>>> rtl/core/fca_dp.sv
// Datapath: bump pointer, free stack, remainder unit, result and output registers
module fca_dp #(
   parameter int PAGE_BYTES  = fca_pkg::PAGE_BYTES_DEF,
   parameter int STACK_DEPTH = fca_pkg::STACK_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fca_pkg::dp_cmd_type          cmd,
   output fca_pkg::dp_sts_type          sts,
   input  logic [fca_pkg::CHUNK_W-1:0]  chunk_size,
   input  logic [fca_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [fca_pkg::OFFSET_W-1:0] req_chunk_offset,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [fca_pkg::OFFSET_W-1:0] rsp_granted_offset,
   output logic [fca_pkg::STATUS_W-1:0] rsp_status
);
   import fca_pkg::*;

   localparam int BUMP_W  = $clog2(PAGE_BYTES + 1);
   localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int SUM_W   = ((BUMP_W > CHUNK_W) ? BUMP_W : CHUNK_W) + 1;
   localparam int CMP_W   = (BUMP_W > OFFSET_W) ? BUMP_W : OFFSET_W;

   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [BUMP_W-1:0]   bump_ff, bump_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [OFFSET_W-1:0] res_offset_ff, res_offset_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rd_ff;
   logic [OFFSET_W-1:0] stack_mem [STACK_DEPTH];
   logic [SUM_W-1:0]    bump_sum;
   logic [ADDR_W-1:0]   push_idx, pop_idx;
   logic                div_busy, rem_zero;

   // Remainder of the freed offset by the chunk size
   fca_rem u_rem (
      .clock          (clock),
      .reset          (reset),
      .start          (cmd.div_start),
      .dividend       (off_ff),
      .divisor        (chunk_size),
      .busy           (div_busy),
      .remainder_zero (rem_zero)
   );

   assign bump_sum = SUM_W'(bump_ff) + SUM_W'(chunk_size);
   assign push_idx = ADDR_W'(count_ff);
   assign pop_idx  = ADDR_W'(count_ff - 1'b1);

   // Status toward the controller
   always_comb begin
      sts.cfg_zero    = (chunk_size == '0);
      sts.op_free     = (op_ff == OP_FREE);
      sts.stack_empty = (count_ff == '0);
      sts.stack_full  = (count_ff == COUNT_W'(STACK_DEPTH));
      sts.oom         = (bump_sum > SUM_W'(PAGE_BYTES));
      sts.off_ge_bump = (CMP_W'(off_ff) >= CMP_W'(bump_ff));
      sts.div_busy    = div_busy;
      sts.rem_zero    = rem_zero;
      sts.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Next-state logic for request, allocator state and result
   always_comb begin
      op_in         = op_ff;
      off_in        = off_ff;
      bump_in       = bump_ff;
      count_in      = count_ff;
      res_offset_in = res_offset_ff;
      res_status_in = res_status_ff;
      if (cmd.capture) begin
         op_in  = req_opcode;
         off_in = req_chunk_offset;
      end
      if (cmd.set_res) begin
         res_offset_in = '0;
         res_status_in = cmd.res_code;
      end
      if (cmd.grant_bump) begin
         res_offset_in = OFFSET_W'(bump_ff);
         res_status_in = STATUS_OK;
         bump_in       = BUMP_W'(bump_sum);
      end
      if (cmd.pop_read) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.pop_take) begin
         res_offset_in = rd_ff;
         res_status_in = STATUS_OK;
      end
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end
   end

   // Output register: drains on handshake, refills from the result
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = res_offset_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bump_ff      <= bump_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      off_ff        <= off_in;
      res_offset_ff <= res_offset_in;
      res_status_ff <= res_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Free stack memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[push_idx] <= off_ff;
      end
      if (cmd.pop_read) begin
         rd_ff <= stack_mem[pop_idx];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_offset = rsp_offset_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (count_ff < COUNT_W'(STACK_DEPTH)))
      else $error("push with full free stack");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_read |-> (count_ff != '0))
      else $error("pop from empty free stack");
   a_bump_in_page: assert property (@(posedge clock) disable iff (reset)
      cmd.grant_bump |=> (bump_ff <= BUMP_W'(PAGE_BYTES)))
      else $error("bump pointer past page end");
   a_fail_zero_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |-> (rsp_offset_ff == '0))
      else $error("failed beat carries nonzero offset");
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten");
`endif

endmodule

>>> rtl/core/fca_ctrl.sv
// Controller: sequences one request at a time through the datapath
module fca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fca_pkg::dp_sts_type sts,
   output fca_pkg::dp_cmd_type cmd
);
   import fca_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.res_code = STATUS_OK;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FINISH;
            if (sts.cfg_zero) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = STATUS_NOCFG;
            end else if (!sts.op_free) begin
               if (!sts.stack_empty) begin
                  cmd.pop_read = 1'b1;
                  state_in     = ST_POP;
               end else if (sts.oom) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = STATUS_OOM;
               end else begin
                  cmd.grant_bump = 1'b1;
               end
            end else if (sts.off_ge_bump || sts.stack_full) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = STATUS_BAD_FREE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               cmd.set_res = 1'b1;
               state_in    = ST_FINISH;
               if (sts.rem_zero) begin
                  cmd.push     = 1'b1;
                  cmd.res_code = STATUS_OK;
               end else begin
                  cmd.res_code = STATUS_BAD_FREE;
               end
            end
         end
         ST_POP: begin
            cmd.pop_take = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
